/* hw/rtl/sgss_pkg.sv */
// ----------------------------------------------------------------------------
// Serpentine grid scan sequencer package
// Shared types, codes and configuration reset values.
// ----------------------------------------------------------------------------
package sgss_pkg;

  localparam int unsigned DistW    = 20;
  localparam int unsigned CountW   = 8;
  localparam int unsigned OutDistW = 28;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [DistW-1:0]  StrokeXRst  = DistW'(5000);
  localparam logic [DistW-1:0]  StepYRst    = DistW'(500);
  localparam logic [DistW-1:0]  PitchXRst   = DistW'(10000);
  localparam logic [DistW-1:0]  PitchYRst   = DistW'(10000);
  localparam logic [CountW-1:0] CellsXRst   = CountW'(1);
  localparam logic [CountW-1:0] CellsYRst   = CountW'(1);
  localparam logic [CountW-1:0] StrokesRst  = CountW'(10);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_STROKE_X = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_STEP_Y   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PITCH_X  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PITCH_Y  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CELLS_X  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_CELLS_Y  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_STROKES  = 3'd6;

  localparam logic DIR_BACK = 1'b0;
  localparam logic DIR_FWD  = 1'b1;
  localparam logic AXIS_X   = 1'b0;
  localparam logic AXIS_Y   = 1'b1;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_START  = 3'd1,
    CMD_STOP   = 3'd2,
    CMD_PAUSE  = 3'd3,
    CMD_RESUME = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    EVT_NONE      = 4'd0,
    EVT_STARTED   = 4'd1,
    EVT_STOPPED   = 4'd2,
    EVT_PAUSED    = 4'd3,
    EVT_RESUMED   = 4'd4,
    EVT_CELL_DONE = 4'd5,
    EVT_RET_DONE  = 4'd6,
    EVT_NEXT_COL  = 4'd7,
    EVT_NEXT_ROW  = 4'd8,
    EVT_COMPLETED = 4'd9
  } evt_e;

  localparam logic [1:0] RUN_IDLE  = 2'd0;
  localparam logic [1:0] RUN_RUN   = 2'd1;
  localparam logic [1:0] RUN_PAUSE = 2'd2;
  localparam logic [1:0] RUN_DONE  = 2'd3;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_RUN   = 4'b0010,
    MODE_PAUSE = 4'b0100,
    MODE_DONE  = 4'b1000
  } mode_e;

  typedef enum logic [3:0] {
    TOP_CELL    = 4'b0001,
    TOP_RETURN  = 4'b0010,
    TOP_ADVANCE = 4'b0100,
    TOP_SETTLE  = 4'b1000
  } top_e;

  typedef enum logic [4:0] {
    CELL_FIRST  = 5'b00001,
    CELL_WAIT_F = 5'b00010,
    CELL_CHECK  = 5'b00100,
    CELL_WAIT_Y = 5'b01000,
    CELL_WAIT_X = 5'b10000
  } cell_e;

  typedef enum logic [2:0] {
    RET_X      = 3'b001,
    RET_WAIT_X = 3'b010,
    RET_WAIT_Y = 3'b100
  } ret_e;

  typedef struct packed {
    logic [2:0] command;
    logic       motor_x_busy;
    logic       motor_y_busy;
  } in_item_t;

  typedef struct packed {
    logic                move_valid;
    logic                move_axis;
    logic                move_dir;
    logic [OutDistW-1:0] move_distance_um;
    logic [3:0]          event_code;
    logic [1:0]          run_mode;
  } out_item_t;

  typedef struct packed {
    logic [DistW-1:0]  stroke_x_um;
    logic [DistW-1:0]  step_y_um;
    logic [DistW-1:0]  cell_pitch_x_um;
    logic [DistW-1:0]  cell_pitch_y_um;
    logic [CountW-1:0] cells_x;
    logic [CountW-1:0] cells_y;
    logic [CountW-1:0] strokes_per_cell;
  } cfg_t;

  function automatic logic [1:0] mode_code(mode_e m);
    logic [1:0] c;
    case (m)
      MODE_RUN:   c = RUN_RUN;
      MODE_PAUSE: c = RUN_PAUSE;
      MODE_DONE:  c = RUN_DONE;
      default:    c = RUN_IDLE;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/sgss_core.sv */
// ----------------------------------------------------------------------------
// Scan sequencer core
// Holds the scan state and turns one command into one result per step.
// ----------------------------------------------------------------------------
module sgss_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  sgss_pkg::in_item_t item_i,
  input  sgss_pkg::cfg_t     cfg_i,
  output sgss_pkg::out_item_t result_o
);
  import sgss_pkg::*;

  mode_e             mode_q, mode_d;
  top_e              top_q, top_d;
  logic              cell_active_q, cell_active_d;
  cell_e             cell_q, cell_d;
  logic [CountW-1:0] stroke_cnt_q, stroke_cnt_d;
  logic              stroke_dir_q, stroke_dir_d;
  ret_e              ret_q, ret_d;
  logic              row_dir_q, row_dir_d;
  logic [CountW-1:0] col_idx_q, col_idx_d;
  logic [CountW-1:0] row_idx_q, row_idx_d;

  out_item_t         res;
  logic              xb, yb;
  logic [OutDistW-1:0] ret_y_dist;

  assign xb = item_i.motor_x_busy;
  assign yb = item_i.motor_y_busy;
  // 20x8 product always fits the 28-bit result, so no clamp is needed
  assign ret_y_dist = OutDistW'(cfg_i.step_y_um) * OutDistW'(cfg_i.strokes_per_cell);

  always_comb begin
    mode_d        = mode_q;
    top_d         = top_q;
    cell_active_d = cell_active_q;
    cell_d        = cell_q;
    stroke_cnt_d  = stroke_cnt_q;
    stroke_dir_d  = stroke_dir_q;
    ret_d         = ret_q;
    row_dir_d     = row_dir_q;
    col_idx_d     = col_idx_q;
    row_idx_d     = row_idx_q;
    res           = '0;

    case (item_i.command)
      CMD_TICK: begin
        if (mode_q == MODE_RUN) begin
          case (top_q)
            TOP_CELL: begin
              if (!cell_active_q) begin
                cell_active_d = 1'b1;
                cell_d        = CELL_FIRST;
                stroke_cnt_d  = '0;
                stroke_dir_d  = DIR_BACK;
              end
              case (cell_d)
                CELL_FIRST: begin
                  res.move_valid       = 1'b1;
                  res.move_axis        = AXIS_X;
                  res.move_dir         = DIR_FWD;
                  res.move_distance_um = OutDistW'(cfg_i.stroke_x_um);
                  cell_d               = CELL_WAIT_F;
                end
                CELL_WAIT_F: begin
                  if (!xb) cell_d = CELL_CHECK;
                end
                CELL_CHECK: begin
                  if (stroke_cnt_d < cfg_i.strokes_per_cell) begin
                    res.move_valid       = 1'b1;
                    res.move_axis        = AXIS_Y;
                    res.move_dir         = DIR_FWD;
                    res.move_distance_um = OutDistW'(cfg_i.step_y_um);
                    cell_d               = CELL_WAIT_Y;
                  end else begin
                    cell_active_d  = 1'b0;
                    cell_d         = CELL_FIRST;
                    stroke_cnt_d   = '0;
                    top_d          = TOP_RETURN;
                    res.event_code = EVT_CELL_DONE;
                  end
                end
                CELL_WAIT_Y: begin
                  if (!yb) begin
                    res.move_valid       = 1'b1;
                    res.move_axis        = AXIS_X;
                    res.move_dir         = stroke_dir_d;
                    res.move_distance_um = OutDistW'(cfg_i.stroke_x_um);
                    cell_d               = CELL_WAIT_X;
                  end
                end
                CELL_WAIT_X: begin
                  if (!xb) begin
                    stroke_dir_d = ~stroke_dir_d;
                    stroke_cnt_d = stroke_cnt_d + CountW'(1);
                    cell_d       = CELL_CHECK;
                  end
                end
                default: cell_d = CELL_FIRST;
              endcase
            end
            TOP_RETURN: begin
              case (ret_q)
                RET_X: begin
                  res.move_valid       = 1'b1;
                  res.move_axis        = AXIS_X;
                  res.move_dir         = DIR_BACK;
                  res.move_distance_um = OutDistW'(cfg_i.stroke_x_um);
                  ret_d                = RET_WAIT_X;
                end
                RET_WAIT_X: begin
                  if (!xb) begin
                    res.move_valid       = 1'b1;
                    res.move_axis        = AXIS_Y;
                    res.move_dir         = DIR_BACK;
                    res.move_distance_um = ret_y_dist;
                    ret_d                = RET_WAIT_Y;
                  end
                end
                RET_WAIT_Y: begin
                  if (!yb) begin
                    ret_d          = RET_X;
                    top_d          = TOP_ADVANCE;
                    res.event_code = EVT_RET_DONE;
                  end
                end
                default: ret_d = RET_X;
              endcase
            end
            TOP_ADVANCE: begin
              // 9-bit compares: a zero cell count acts as one cell
              if (({1'b0, col_idx_q} + 9'd1) < {1'b0, cfg_i.cells_x}) begin
                res.move_valid       = 1'b1;
                res.move_axis        = AXIS_X;
                res.move_dir         = row_dir_q;
                res.move_distance_um = OutDistW'(cfg_i.cell_pitch_x_um);
                col_idx_d            = col_idx_q + CountW'(1);
                top_d                = TOP_SETTLE;
                res.event_code       = EVT_NEXT_COL;
              end else if (({1'b0, row_idx_q} + 9'd1) < {1'b0, cfg_i.cells_y}) begin
                res.move_valid       = 1'b1;
                res.move_axis        = AXIS_Y;
                res.move_dir         = DIR_FWD;
                res.move_distance_um = OutDistW'(cfg_i.cell_pitch_y_um);
                row_idx_d            = row_idx_q + CountW'(1);
                row_dir_d            = ~row_dir_q;
                col_idx_d            = '0;
                top_d                = TOP_SETTLE;
                res.event_code       = EVT_NEXT_ROW;
              end else begin
                mode_d         = MODE_DONE;
                top_d          = TOP_CELL;
                res.event_code = EVT_COMPLETED;
              end
            end
            TOP_SETTLE: begin
              if (!xb && !yb) top_d = TOP_CELL;
            end
            default: top_d = TOP_CELL;
          endcase
        end
      end
      CMD_START: begin
        if (mode_q == MODE_IDLE || mode_q == MODE_DONE) begin
          cell_active_d  = 1'b0;
          cell_d         = CELL_FIRST;
          stroke_cnt_d   = '0;
          stroke_dir_d   = DIR_BACK;
          ret_d          = RET_X;
          col_idx_d      = '0;
          row_idx_d      = '0;
          top_d          = TOP_CELL;
          mode_d         = MODE_RUN;
          res.event_code = EVT_STARTED;
        end
      end
      CMD_STOP: begin
        if (mode_q == MODE_RUN || mode_q == MODE_PAUSE) begin
          mode_d         = MODE_IDLE;
          cell_active_d  = 1'b0;
          cell_d         = CELL_FIRST;
          stroke_cnt_d   = '0;
          stroke_dir_d   = DIR_BACK;
          ret_d          = RET_X;
          res.event_code = EVT_STOPPED;
        end
      end
      CMD_PAUSE: begin
        if (mode_q == MODE_RUN) begin
          mode_d         = MODE_PAUSE;
          res.event_code = EVT_PAUSED;
        end
      end
      CMD_RESUME: begin
        if (mode_q == MODE_PAUSE) begin
          mode_d         = MODE_RUN;
          res.event_code = EVT_RESUMED;
        end
      end
      default: ;
    endcase

    res.run_mode = mode_code(mode_d);
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_IDLE;
      top_q         <= TOP_CELL;
      cell_active_q <= 1'b0;
      cell_q        <= CELL_FIRST;
      stroke_cnt_q  <= '0;
      stroke_dir_q  <= DIR_BACK;
      ret_q         <= RET_X;
      row_dir_q     <= DIR_FWD;
      col_idx_q     <= '0;
      row_idx_q     <= '0;
    end else if (step_i) begin
      mode_q        <= mode_d;
      top_q         <= top_d;
      cell_active_q <= cell_active_d;
      cell_q        <= cell_d;
      stroke_cnt_q  <= stroke_cnt_d;
      stroke_dir_q  <= stroke_dir_d;
      ret_q         <= ret_d;
      row_dir_q     <= row_dir_d;
      col_idx_q     <= col_idx_d;
      row_idx_q     <= row_idx_d;
    end
  end

endmodule

/* hw/rtl/serpentine_grid_scan_sequencer.sv */
// ----------------------------------------------------------------------------
// Serpentine grid scan sequencer
// A command is held in the input register, and its result is written into the
// result register once that register is free or draining; a stall can hold it.
// Throughput: one command per cycle while out_stall_i is low; the input register
// frees as the result register hands over, so both sides stream without bubbles.
// Reset: asynchronous; scan state, handshake and configuration registers
// return to their reset values at once.
// ----------------------------------------------------------------------------
module serpentine_grid_scan_sequencer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  sgss_pkg::in_item_t           in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output sgss_pkg::out_item_t          out_item_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sgss_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [sgss_pkg::DistW-1:0]   cfg_data_i
);
  import sgss_pkg::*;

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t result;
  cfg_t      cfg_q;
  logic      step;
  logic      in_take;

  // process the held command when the result register is free or draining
  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take || step) begin
      in_valid_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) in_item_q <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) out_item_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stroke_x_um      <= StrokeXRst;
      cfg_q.step_y_um        <= StepYRst;
      cfg_q.cell_pitch_x_um  <= PitchXRst;
      cfg_q.cell_pitch_y_um  <= PitchYRst;
      cfg_q.cells_x          <= CellsXRst;
      cfg_q.cells_y          <= CellsYRst;
      cfg_q.strokes_per_cell <= StrokesRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_STROKE_X: cfg_q.stroke_x_um      <= cfg_data_i;
        CFG_STEP_Y:   cfg_q.step_y_um        <= cfg_data_i;
        CFG_PITCH_X:  cfg_q.cell_pitch_x_um  <= cfg_data_i;
        CFG_PITCH_Y:  cfg_q.cell_pitch_y_um  <= cfg_data_i;
        CFG_CELLS_X:  cfg_q.cells_x          <= cfg_data_i[CountW-1:0];
        CFG_CELLS_Y:  cfg_q.cells_y          <= cfg_data_i[CountW-1:0];
        CFG_STROKES:  cfg_q.strokes_per_cell <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  sgss_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  // an empty input register never pushes back
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> !in_stall_o)
    else $error("input stalled with empty input register");

  // every processed command lands in the result register
  a_step_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("processed command produced no result");

  // completion event always reports the completed mode
  a_completed_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && result.event_code == EVT_COMPLETED) |=> (out_item_q.run_mode == RUN_DONE))
    else $error("completion event without completed run mode");

  // stop always lands in idle
  a_stop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && result.event_code == EVT_STOPPED) |=> (out_item_q.run_mode == RUN_IDLE))
    else $error("stop event without idle run mode");

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// Serpentine grid scan sequencer testbench
// Drives command transactions and configuration writes, predicts every result
// with a cycle-free scan model and checks each output transaction in order.
// ----------------------------------------------------------------------------
module tb;
  import sgss_pkg::*;

  localparam int QuietLimit    = 1000;
  localparam int ItemsPerPhase = 195;
  localparam int NumPhases     = 10;
  localparam logic [OutDistW-1:0] DistSat = '1;

  // command and register codes outside the defined set
  localparam logic [2:0]         CMD_RSVD5  = 3'd5;
  localparam logic [2:0]         CMD_RSVD6  = 3'd6;
  localparam logic [2:0]         CMD_RSVD7  = 3'd7;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 3'd7;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_item_t            in_item_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_item_t           out_item_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [DistW-1:0]    cfg_data_i;

  int mismatches = 0;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 40) $display("ERROR %s", msg);
  endtask

  class scan_scoreboard;
    cfg_t              regs;
    logic [1:0]        run_mode;
    top_e              top_ph;
    logic              cell_on;
    cell_e             cell_ph;
    logic [CountW-1:0] strokes_done;
    logic              stroke_dir;
    ret_e              ret_ph;
    logic              row_dir;
    logic [CountW-1:0] col_idx;
    logic [CountW-1:0] row_idx;
    out_item_t         expected_q[$];

    function new();
      regs = '{StrokeXRst, StepYRst, PitchXRst, PitchYRst, CellsXRst, CellsYRst, StrokesRst};
      run_mode = RUN_IDLE;
      top_ph = TOP_CELL;
      clear_progress();
      row_dir = DIR_FWD;
      col_idx = '0;
      row_idx = '0;
    endfunction

    function void clear_progress();
      cell_on = 1'b0;
      cell_ph = CELL_FIRST;
      strokes_done = '0;
      stroke_dir = DIR_BACK;
      ret_ph = RET_X;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [DistW-1:0] data);
      case (idx)
        CFG_STROKE_X: regs.stroke_x_um = data;
        CFG_STEP_Y:   regs.step_y_um = data;
        CFG_PITCH_X:  regs.cell_pitch_x_um = data;
        CFG_PITCH_Y:  regs.cell_pitch_y_um = data;
        CFG_CELLS_X:  regs.cells_x = data[CountW-1:0];
        CFG_CELLS_Y:  regs.cells_y = data[CountW-1:0];
        CFG_STROKES:  regs.strokes_per_cell = data[CountW-1:0];
        default: ;
      endcase
    endfunction

    function void order_move(inout out_item_t r, input logic axis, input logic dir,
                             input longint unsigned len_um);
      r.move_valid = 1'b1;
      r.move_axis = axis;
      r.move_dir = dir;
      r.move_distance_um = (len_um > DistSat) ? DistSat : len_um[OutDistW-1:0];
    endfunction

    function void advance_scan(logic xb, logic yb, inout out_item_t r);
      case (top_ph)
        TOP_CELL: begin
          if (!cell_on) begin
            cell_on = 1'b1;
            cell_ph = CELL_FIRST;
            strokes_done = '0;
            stroke_dir = DIR_BACK;
          end
          case (cell_ph)
            CELL_FIRST: begin
              order_move(r, AXIS_X, DIR_FWD, regs.stroke_x_um);
              cell_ph = CELL_WAIT_F;
            end
            CELL_WAIT_F: if (!xb) cell_ph = CELL_CHECK;
            CELL_CHECK: begin
              if (strokes_done < regs.strokes_per_cell) begin
                order_move(r, AXIS_Y, DIR_FWD, regs.step_y_um);
                cell_ph = CELL_WAIT_Y;
              end else begin
                cell_on = 1'b0;
                cell_ph = CELL_FIRST;
                strokes_done = '0;
                top_ph = TOP_RETURN;
                r.event_code = EVT_CELL_DONE;
              end
            end
            CELL_WAIT_Y: begin
              if (!yb) begin
                order_move(r, AXIS_X, stroke_dir, regs.stroke_x_um);
                cell_ph = CELL_WAIT_X;
              end
            end
            default: begin
              if (!xb) begin
                stroke_dir = ~stroke_dir;
                strokes_done = strokes_done + 1'b1;
                cell_ph = CELL_CHECK;
              end
            end
          endcase
        end
        TOP_RETURN: begin
          case (ret_ph)
            RET_X: begin
              order_move(r, AXIS_X, DIR_BACK, regs.stroke_x_um);
              ret_ph = RET_WAIT_X;
            end
            RET_WAIT_X: begin
              if (!xb) begin
                // Y comes back over every step taken inside the cell
                order_move(r, AXIS_Y, DIR_BACK,
                           longint'(regs.step_y_um) * longint'(regs.strokes_per_cell));
                ret_ph = RET_WAIT_Y;
              end
            end
            default: begin
              if (!yb) begin
                ret_ph = RET_X;
                top_ph = TOP_ADVANCE;
                r.event_code = EVT_RET_DONE;
              end
            end
          endcase
        end
        TOP_ADVANCE: begin
          if (int'(col_idx) + 1 < int'(regs.cells_x)) begin
            order_move(r, AXIS_X, row_dir, regs.cell_pitch_x_um);
            col_idx = col_idx + 1'b1;
            top_ph = TOP_SETTLE;
            r.event_code = EVT_NEXT_COL;
          end else if (int'(row_idx) + 1 < int'(regs.cells_y)) begin
            order_move(r, AXIS_Y, DIR_FWD, regs.cell_pitch_y_um);
            row_idx = row_idx + 1'b1;
            row_dir = ~row_dir;
            col_idx = '0;
            top_ph = TOP_SETTLE;
            r.event_code = EVT_NEXT_ROW;
          end else begin
            run_mode = RUN_DONE;
            top_ph = TOP_CELL;
            r.event_code = EVT_COMPLETED;
          end
        end
        default: if (!xb && !yb) top_ph = TOP_CELL;
      endcase
    endfunction

    // returns 1 when the command does more than being ignored
    function bit note_command(in_item_t it);
      out_item_t r;
      bit acted;
      r = '0;
      acted = 1'b0;
      case (it.command)
        CMD_TICK: begin
          if (run_mode == RUN_RUN) begin
            advance_scan(it.motor_x_busy, it.motor_y_busy, r);
            acted = 1'b1;
          end
        end
        CMD_START: begin
          if (run_mode == RUN_IDLE || run_mode == RUN_DONE) begin
            clear_progress();
            col_idx = '0;
            row_idx = '0;
            top_ph = TOP_CELL;
            run_mode = RUN_RUN;
            r.event_code = EVT_STARTED;
          end
        end
        CMD_STOP: begin
          if (run_mode == RUN_RUN || run_mode == RUN_PAUSE) begin
            run_mode = RUN_IDLE;
            clear_progress();
            r.event_code = EVT_STOPPED;
          end
        end
        CMD_PAUSE: begin
          if (run_mode == RUN_RUN) begin
            run_mode = RUN_PAUSE;
            r.event_code = EVT_PAUSED;
          end
        end
        CMD_RESUME: begin
          if (run_mode == RUN_PAUSE) begin
            run_mode = RUN_RUN;
            r.event_code = EVT_RESUMED;
          end
        end
        default: ;
      endcase
      r.run_mode = run_mode;
      expected_q.push_back(r);
      return acted || (r.event_code != EVT_NONE);
    endfunction

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s: got %0h want %0h", name, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result transaction with no command pending");
      end else begin
        want = expected_q.pop_front();
        compare_field("move_valid", got.move_valid, want.move_valid);
        compare_field("move_axis", got.move_axis, want.move_axis);
        compare_field("move_dir", got.move_dir, want.move_dir);
        compare_field("move_distance_um", got.move_distance_um, want.move_distance_um);
        compare_field("event_code", got.event_code, want.event_code);
        compare_field("run_mode", got.run_mode, want.run_mode);
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  scan_scoreboard sb;

  serpentine_grid_scan_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rcv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_item_o);
  end

  // watchdog: cycles with no transaction on any channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (rst_ni && ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
                     (cfg_valid_i && cfg_ready_o)))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL serpentine_grid_scan_sequencer");
    $finish;
  end

  function automatic in_item_t mk_command(logic [2:0] cmd, logic xb, logic yb);
    in_item_t it;
    it.command = cmd;
    it.motor_x_busy = xb;
    it.motor_y_busy = yb;
    return it;
  endfunction

  // mostly well-formed scans; the rest is noise and wrong-mode commands
  function automatic in_item_t gen_command();
    int r;
    r = $urandom_range(99);
    case (sb.run_mode)
      RUN_RUN: begin
        if (r < 88)
          return mk_command(CMD_TICK, $urandom_range(99) < 35, $urandom_range(99) < 35);
        if (r < 91) return mk_command(CMD_PAUSE, 1'($urandom), 1'($urandom));
        if (r < 92) return mk_command(CMD_STOP, 1'($urandom), 1'($urandom));
      end
      RUN_PAUSE: begin
        if (r < 50) return mk_command(CMD_RESUME, 1'($urandom), 1'($urandom));
        if (r < 55) return mk_command(CMD_STOP, 1'($urandom), 1'($urandom));
      end
      default: if (r < 75) return mk_command(CMD_START, 1'($urandom), 1'($urandom));
    endcase
    return mk_command(3'($urandom_range(7)), 1'($urandom), 1'($urandom));
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DistW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_command(in_item_t it, output bit acted);
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    acted = sb.note_command(it);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic configure_phase(int p);
    logic [DistW-1:0]  lens[4];
    logic [CountW-1:0] cnt[3];
    for (int i = 0; i < 4; i++) lens[i] = DistW'($urandom);
    cnt[0] = CountW'($urandom_range(4));
    cnt[1] = CountW'($urandom_range(3));
    cnt[2] = CountW'($urandom_range(4));
    case (p)
      1: begin
        lens = '{default: '0};
        cnt = '{default: '0};
      end
      2: begin
        lens = '{default: '1};
        cnt = '{default: '1};
      end
      3: cnt = '{8'd255, 8'd2, 8'd0};
      4: cnt = '{8'd1, 8'd255, 8'd0};
      default: ;
    endcase
    write_reg(CFG_STROKE_X, lens[0]);
    write_reg(CFG_STEP_Y, lens[1]);
    write_reg(CFG_PITCH_X, lens[2]);
    write_reg(CFG_PITCH_Y, lens[3]);
    // upper data bits are random; count registers keep only the low byte
    write_reg(CFG_CELLS_X, {(DistW-CountW)'($urandom), cnt[0]});
    write_reg(CFG_CELLS_Y, {(DistW-CountW)'($urandom), cnt[1]});
    write_reg(CFG_STROKES, {(DistW-CountW)'($urandom), cnt[2]});
    write_reg(CFG_UNUSED, DistW'($urandom));
  endtask

  initial begin
    in_item_t directed[$];
    bit acted;
    int count;
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_reg(CFG_UNUSED, DistW'($urandom));

    // wrong-mode and unknown commands, then a short scan with pause and stop
    directed = '{
      mk_command(CMD_TICK, 1'b0, 1'b0),   mk_command(CMD_STOP, 1'b1, 1'b0),
      mk_command(CMD_PAUSE, 1'b0, 1'b1),  mk_command(CMD_RESUME, 1'b1, 1'b1),
      mk_command(CMD_RSVD5, 1'b1, 1'b1),  mk_command(CMD_RSVD6, 1'b0, 1'b0),
      mk_command(CMD_RSVD7, 1'b1, 1'b1),  mk_command(CMD_START, 1'b0, 1'b0),
      mk_command(CMD_START, 1'b0, 1'b0),  mk_command(CMD_RESUME, 1'b0, 1'b0),
      mk_command(CMD_PAUSE, 1'b0, 1'b0),  mk_command(CMD_PAUSE, 1'b0, 1'b0),
      mk_command(CMD_TICK, 1'b0, 1'b0),   mk_command(CMD_STOP, 1'b0, 1'b0),
      mk_command(CMD_START, 1'b1, 1'b1),  mk_command(CMD_TICK, 1'b1, 1'b1),
      mk_command(CMD_TICK, 1'b1, 1'b0),   mk_command(CMD_TICK, 1'b0, 1'b1),
      mk_command(CMD_TICK, 1'b0, 1'b1),   mk_command(CMD_TICK, 1'b1, 1'b1),
      mk_command(CMD_TICK, 1'b1, 1'b0),   mk_command(CMD_PAUSE, 1'b0, 1'b0),
      mk_command(CMD_RESUME, 1'b0, 1'b0), mk_command(CMD_STOP, 1'b0, 1'b0)
    };
    foreach (directed[i]) send_command(directed[i], acted);
    drain();

    for (int p = 1; p <= NumPhases; p++) begin
      case (p % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 57; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 57; end
        default: begin snd_idle_pct = 14; rcv_stall_pct = 14; end
      endcase
      configure_phase(p);
      count = 0;
      while (count < ItemsPerPhase) begin
        send_command(gen_command(), acted);
        count += acted;
      end
      drain();
    end

    repeat (4) @(posedge clk_i);
    if (mismatches == 0)
      $display("PASS serpentine_grid_scan_sequencer");
    else
      $display("FAIL serpentine_grid_scan_sequencer");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/sgss_pkg.sv
hw/rtl/sgss_core.sv
hw/rtl/serpentine_grid_scan_sequencer.sv
tb/tb.sv
